// ===== rtl/dif3d_pkg.sv =====
// Shared constants, widths and types of the 3D diffusion stencil block.
package dif3d_pkg;

  // Number formats.
  localparam int VALUE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int GAIN_W     = 18;

  // Box limits and coordinate widths.
  localparam int MAX_X    = 1024;
  localparam int MAX_Y    = 64;
  localparam int MAX_Z    = 64;
  localparam int EXT_X_W  = 11;
  localparam int EXT_YZ_W = 7;
  localparam int POS_X_W  = $clog2(MAX_X);
  localparam int POS_Y_W  = $clog2(MAX_Y);
  localparam int POS_Z_W  = $clog2(MAX_Z);
  localparam int PX_W     = 10;
  localparam int PY_W     = 6;
  localparam int PZ_W     = 6;

  // Plane stores: two planes of old values, one plane of accumulators.
  localparam int PLANE     = MAX_Y * MAX_Z;
  localparam int PLANE_AW  = $clog2(PLANE);
  localparam int OLD_DEPTH = 2 * PLANE;
  localparam int OLD_AW    = PLANE_AW + 1;

  // Arithmetic widths along the datapath.
  localparam int D2_W   = VALUE_BITS + 2;
  localparam int PROD_W = D2_W + GAIN_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int SHR_W  = SUM_W - FRAC_BITS;
  localparam int RES_W  = SHR_W + 1;

  // Stream and configuration port widths.
  localparam int IN_DATA_W   = 2 * VALUE_BITS;
  localparam int OUT_FIELD_W = VALUE_BITS + PX_W + PY_W + PZ_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_X   = 3'd0,
    REG_GAIN_Y   = 3'd1,
    REG_GAIN_Z   = 3'd2,
    REG_EXTENT_X = 3'd3,
    REG_EXTENT_Y = 3'd4,
    REG_EXTENT_Z = 3'd5
  } cfg_reg_t;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // Coordinates and end-of-box mark that ride along with a result.
  typedef struct packed {
    logic            last;
    logic [PZ_W-1:0] pz;
    logic [PY_W-1:0] py;
    logic [PX_W-1:0] px;
  } point_t;

endpackage

// ===== rtl/diffusion_stencil_3d.sv =====
// Seven-point 3D Laplacian diffusion update over a streamed box of grid points.
//
//  Channel  | Direction | Signals                    | Contents
//  ---------+-----------+----------------------------+-----------------------------------
//  s_*      | in        | s_tvalid/s_tready/s_tdata  | old_value, accum_value per point
//  m_*      | out       | m_tvalid/m_tready/m_tdata  | new_value, point_x/y/z; tlast=last
//  cfg_*    | in        | cfg_wr_en/cfg_index/data   | gains and box extents, write only
//
// One point is taken per cycle while s_tready is high; a result passes registers for the
// plane store read, second differences, products, sum, and floor shift and saturate. The
// old-value plane store is held in three copies, each with two read ports, so the center
// and five neighbors are read in the accepting cycle; the +x neighbor is the arriving
// value. Reset clears the position counters, the stage valid bits and the configuration
// registers; the plane stores are not cleared. Each stage holds while the next is full
// and stalled, so bubbles are squeezed out before the input is held.
module diffusion_stencil_3d (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] old_value, [63:32] accum_value
  input  logic [dif3d_pkg::IN_DATA_W-1:0]     s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] new_value, [41:32] point_x, [47:42] point_y, [53:48] point_z, rest zero
  output logic [dif3d_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic                                m_tlast,
  input  logic                                cfg_wr_en,
  input  logic [dif3d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dif3d_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import dif3d_pkg::*;

  localparam logic signed [RES_W-1:0] SAT_HI = (RES_W'(1) <<< (VALUE_BITS - 1)) - RES_W'(1);
  localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

  // Configuration registers; extents are kept already clamped.
  logic [GAIN_W-1:0]   gain_x, gain_y, gain_z;
  logic [EXT_X_W-1:0]  ext_x;
  logic [EXT_YZ_W-1:0] ext_y, ext_z;
  logic [EXT_X_W-1:0]  ext_x_wr;
  logic [EXT_YZ_W-1:0] ext_y_wr, ext_z_wr;

  // Position of the next arriving point.
  logic [POS_X_W-1:0]  pos_x, pos_x_next;
  logic [POS_Y_W-1:0]  pos_y, pos_y_next;
  logic [POS_Z_W-1:0]  pos_z, pos_z_next;

  logic [EXT_X_W-1:0]  x_inc;
  logic [EXT_YZ_W-1:0] y_inc, y_inc2, z_inc, z_inc2;
  logic                wrap_x, wrap_y, wrap_z;
  logic                interior;
  point_t              in_point;

  // Plane store addressing.
  logic [PLANE_AW-1:0] here;
  logic [OLD_AW-1:0]   addr_now, addr_c, addr_ym, addr_yp, addr_zm, addr_zp;

  value_t cur_old, cur_acc;

  // Plane stores: three identical copies of the old values.
  value_t old_mem_a [0:OLD_DEPTH-1];
  value_t old_mem_b [0:OLD_DEPTH-1];
  value_t old_mem_c [0:OLD_DEPTH-1];
  value_t acc_mem   [0:PLANE-1];
  value_t rd_c, rd_xm, rd_ym, rd_yp, rd_zm, rd_zp, rd_acc;

  // Pipeline handshake.
  logic s_acc;
  logic en1, en2, en3, en4, en5;
  logic s1_valid, s2_valid, s3_valid, s4_valid;

  // Stage registers.
  value_t                   s1_cur;
  point_t                   s1_point;
  logic signed [D2_W-1:0]   d2x, d2y, d2z;
  logic signed [D2_W-1:0]   s2_d2x, s2_d2y, s2_d2z;
  value_t                   s2_acc;
  point_t                   s2_point;
  logic signed [PROD_W-1:0] mul_x, mul_y, mul_z;
  logic signed [PROD_W-1:0] s3_px, s3_py, s3_pz;
  value_t                   s3_acc;
  point_t                   s3_point;
  logic signed [SUM_W-1:0]  s4_sum;
  value_t                   s4_acc;
  point_t                   s4_point;
  logic signed [SHR_W-1:0]  shr;
  logic signed [RES_W-1:0]  res, sat;
  value_t                   out_value;
  point_t                   out_point;

  // Stage enables: a stage loads when it is empty or its successor moves.
  assign en5      = ~m_tvalid | m_tready;
  assign en4      = ~s4_valid | en5;
  assign en3      = ~s3_valid | en4;
  assign en2      = ~s2_valid | en3;
  assign en1      = ~s1_valid | en2;
  assign s_tready = en1;
  assign s_acc    = s_tvalid & en1;

  assign cur_old = s_tdata[VALUE_BITS-1:0];
  assign cur_acc = s_tdata[2*VALUE_BITS-1:VALUE_BITS];

  // Extent clamping for configuration writes.
  always_comb begin
    if (cfg_data[EXT_X_W-1:0] < EXT_X_W'(3)) begin
      ext_x_wr = EXT_X_W'(3);
    end else if (cfg_data[EXT_X_W-1:0] > EXT_X_W'(MAX_X)) begin
      ext_x_wr = EXT_X_W'(MAX_X);
    end else begin
      ext_x_wr = cfg_data[EXT_X_W-1:0];
    end
    if (cfg_data[EXT_YZ_W-1:0] < EXT_YZ_W'(3)) begin
      ext_y_wr = EXT_YZ_W'(3);
    end else if (cfg_data[EXT_YZ_W-1:0] > EXT_YZ_W'(MAX_Y)) begin
      ext_y_wr = EXT_YZ_W'(MAX_Y);
    end else begin
      ext_y_wr = cfg_data[EXT_YZ_W-1:0];
    end
    if (cfg_data[EXT_YZ_W-1:0] < EXT_YZ_W'(3)) begin
      ext_z_wr = EXT_YZ_W'(3);
    end else if (cfg_data[EXT_YZ_W-1:0] > EXT_YZ_W'(MAX_Z)) begin
      ext_z_wr = EXT_YZ_W'(MAX_Z);
    end else begin
      ext_z_wr = cfg_data[EXT_YZ_W-1:0];
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_x <= '0;
      gain_y <= '0;
      gain_z <= '0;
      ext_x  <= EXT_X_W'(3);
      ext_y  <= EXT_YZ_W'(3);
      ext_z  <= EXT_YZ_W'(3);
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAIN_X:   gain_x <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Y:   gain_y <= cfg_data[GAIN_W-1:0];
        REG_GAIN_Z:   gain_z <= cfg_data[GAIN_W-1:0];
        REG_EXTENT_X: ext_x  <= ext_x_wr;
        REG_EXTENT_Y: ext_y  <= ext_y_wr;
        REG_EXTENT_Z: ext_z  <= ext_z_wr;
        default: begin
        end
      endcase
    end
  end

  // Position tracking, interior test and end-of-box mark.
  always_comb begin
    x_inc  = EXT_X_W'(pos_x) + EXT_X_W'(1);
    y_inc  = EXT_YZ_W'(pos_y) + EXT_YZ_W'(1);
    y_inc2 = EXT_YZ_W'(pos_y) + EXT_YZ_W'(2);
    z_inc  = EXT_YZ_W'(pos_z) + EXT_YZ_W'(1);
    z_inc2 = EXT_YZ_W'(pos_z) + EXT_YZ_W'(2);
    wrap_x = x_inc >= ext_x;
    wrap_y = y_inc >= ext_y;
    wrap_z = z_inc >= ext_z;

    pos_x_next = pos_x;
    pos_y_next = pos_y;
    pos_z_next = pos_z;
    if (wrap_z) begin
      pos_z_next = '0;
      if (wrap_y) begin
        pos_y_next = '0;
        pos_x_next = wrap_x ? '0 : x_inc[POS_X_W-1:0];
      end else begin
        pos_y_next = y_inc[POS_Y_W-1:0];
      end
    end else begin
      pos_z_next = z_inc[POS_Z_W-1:0];
    end

    interior = (pos_x >= POS_X_W'(2)) && (pos_y != '0) && (y_inc2 <= ext_y)
            && (pos_z != '0) && (z_inc2 <= ext_z);

    in_point.last = wrap_x && (y_inc2 == ext_y) && (z_inc2 == ext_z);
    in_point.px   = PX_W'(pos_x - POS_X_W'(1));
    in_point.py   = PY_W'(pos_y);
    in_point.pz   = PZ_W'(pos_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0;
      pos_y <= '0;
      pos_z <= '0;
    end else if (s_acc) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      pos_z <= pos_z_next;
    end
  end

  // Plane addresses: the parity of x picks the plane half.
  always_comb begin
    here     = PLANE_AW'(pos_y) * PLANE_AW'(MAX_Z) + PLANE_AW'(pos_z);
    addr_now = {pos_x[0], here};
    addr_c   = {~pos_x[0], here};
    addr_ym  = {~pos_x[0], here - PLANE_AW'(MAX_Z)};
    addr_yp  = {~pos_x[0], here + PLANE_AW'(MAX_Z)};
    addr_zm  = {~pos_x[0], here - PLANE_AW'(1)};
    addr_zp  = {~pos_x[0], here + PLANE_AW'(1)};
  end

  // Store copy A: center and the -x neighbor, read before the new write.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      old_mem_a[addr_now] <= cur_old;
      rd_c                <= old_mem_a[addr_c];
      rd_xm               <= old_mem_a[addr_now];
    end
  end

  // Store copy B: the y neighbors.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      old_mem_b[addr_now] <= cur_old;
      rd_ym               <= old_mem_b[addr_ym];
      rd_yp               <= old_mem_b[addr_yp];
    end
  end

  // Store copy C: the z neighbors.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      old_mem_c[addr_now] <= cur_old;
      rd_zm               <= old_mem_c[addr_zm];
      rd_zp               <= old_mem_c[addr_zp];
    end
  end

  // Accumulator plane store.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      acc_mem[here] <= cur_acc;
      rd_acc        <= acc_mem[here];
    end
  end

  // Valid bits; only points that complete an interior point go on.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) s1_valid <= s_acc & interior;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) s4_valid <= s3_valid;
      if (en5) m_tvalid <= s4_valid;
    end
  end

  // Stage 1: the arriving old value joins the store reads.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_cur   <= cur_old;
      s1_point <= in_point;
    end
  end

  // Stage 2: second differences along each axis.
  always_comb begin
    d2x = D2_W'(s1_cur) - (D2_W'(rd_c) <<< 1) + D2_W'(rd_xm);
    d2y = D2_W'(rd_yp)  - (D2_W'(rd_c) <<< 1) + D2_W'(rd_ym);
    d2z = D2_W'(rd_zp)  - (D2_W'(rd_c) <<< 1) + D2_W'(rd_zm);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_d2x   <= d2x;
      s2_d2y   <= d2y;
      s2_d2z   <= d2z;
      s2_acc   <= rd_acc;
      s2_point <= s1_point;
    end
  end

  // Stage 3: one gain product per axis.
  assign mul_x = PROD_W'($signed({1'b0, gain_x})) * PROD_W'(s2_d2x);
  assign mul_y = PROD_W'($signed({1'b0, gain_y})) * PROD_W'(s2_d2y);
  assign mul_z = PROD_W'($signed({1'b0, gain_z})) * PROD_W'(s2_d2z);

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_px    <= mul_x;
      s3_py    <= mul_y;
      s3_pz    <= mul_z;
      s3_acc   <= s2_acc;
      s3_point <= s2_point;
    end
  end

  // Stage 4: sum of the three products.
  always_ff @(posedge clk) begin
    if (en4) begin
      s4_sum   <= SUM_W'(s3_px) + SUM_W'(s3_py) + SUM_W'(s3_pz);
      s4_acc   <= s3_acc;
      s4_point <= s3_point;
    end
  end

  // Stage 5: floor shift of the sum, add to the accumulator, saturate.
  always_comb begin
    shr = s4_sum[SUM_W-1:FRAC_BITS];
    res = RES_W'(shr) + RES_W'(s4_acc);
    if (res > SAT_HI) begin
      sat = SAT_HI;
    end else if (res < SAT_LO) begin
      sat = SAT_LO;
    end else begin
      sat = res;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_value <= sat[VALUE_BITS-1:0];
      out_point <= s4_point;
    end
  end

  // Output packing.
  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_point.pz, out_point.py, out_point.px, out_value};
  assign m_tlast = out_point.last;

endmodule
